FILE: rtl/core/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg
// shared constants and types of the averaged quad motor mixer
// ----------------------------------------------------------------------------
package qmm_pkg;

  localparam int WINDOW_LENGTH = 5;
  localparam int SAMPLE_BITS   = 12;

  localparam int IN_BITS   = 12;
  localparam int OUT_BITS  = 12;
  localparam int GAIN_BITS = 16;
  localparam int FRAC_BITS = 12;

  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
  localparam int DIV_SHIFT  = SUM_BITS + $clog2(WINDOW_LENGTH);
  localparam int RECIP_BITS = DIV_SHIFT + 1;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));
  localparam int DIV_PROD_BITS = SUM_BITS + RECIP_BITS;

  localparam int CENT_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = GAIN_BITS + CENT_BITS;
  localparam int MIX_BITS  = SAMPLE_BITS + FRAC_BITS + 7;
  localparam int WIDE_BITS = SAMPLE_BITS + OUT_BITS;

  localparam int CENTER    = 1500;
  localparam int LOW_CUT   = 1012;
  localparam int LOW_CUT_Q = LOW_CUT * (2 ** FRAC_BITS);
  localparam int OUT_MAX   = (2 ** OUT_BITS) - 1;

  localparam int CH_COUNT = 4;
  localparam int CH_THR   = 0;
  localparam int CH_ROLL  = 1;
  localparam int CH_PITCH = 2;
  localparam int CH_YAW   = 3;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROLL_GAIN      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_GAIN     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_YAW_GAIN       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PWM_FLOOR      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PWM_CEILING    = 3'd5;

  typedef logic [IN_BITS-1:0]              field_t;
  typedef logic [SAMPLE_BITS-1:0]          sample_t;
  typedef logic [SUM_BITS-1:0]             sum_t;
  typedef logic [DIV_PROD_BITS-1:0]        div_prod_t;
  typedef logic signed [GAIN_BITS-1:0]     gain_t;
  typedef logic signed [CENT_BITS-1:0]     cent_t;
  typedef logic signed [PROD_BITS-1:0]     prod_t;
  typedef logic signed [MIX_BITS-1:0]      mix_t;
  typedef logic [OUT_BITS-1:0]             motor_t;
  typedef logic [CFG_IDX_BITS-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]        cfg_data_t;

  localparam gain_t   GAIN_RESET      = 16'sd4096;
  localparam motor_t  IDLE_RESET      = 12'd1100;
  localparam motor_t  FLOOR_RESET     = 12'd1000;
  localparam motor_t  CEILING_RESET   = 12'd2000;
  localparam sample_t WIN_HEAD_RESET  = SAMPLE_BITS'(1001);

  typedef struct packed {
    gain_t  roll_gain;
    gain_t  pitch_gain;
    gain_t  yaw_gain;
    motor_t idle_threshold;
    motor_t pwm_floor;
    motor_t pwm_ceiling;
  } cfg_t;

endpackage

FILE: rtl/core/qmm_ifs.sv
// ----------------------------------------------------------------------------
// qmm channel interfaces
// valid/ready channels for samples, motor commands and register writes
// ----------------------------------------------------------------------------
interface qmm_in_if;
  import qmm_pkg::*;
  logic   valid;
  logic   ready;
  field_t throttle_sample;
  field_t roll_sample;
  field_t pitch_sample;
  field_t yaw_sample;
  modport source (output valid, throttle_sample, roll_sample, pitch_sample, yaw_sample,
                  input ready);
  modport sink   (input valid, throttle_sample, roll_sample, pitch_sample, yaw_sample,
                  output ready);
endinterface

interface qmm_out_if;
  import qmm_pkg::*;
  logic   valid;
  logic   ready;
  motor_t motor_one;
  motor_t motor_two;
  motor_t motor_three;
  motor_t motor_four;
  logic   idle_bypass;
  modport source (output valid, motor_one, motor_two, motor_three, motor_four, idle_bypass,
                  input ready);
  modport sink   (input valid, motor_one, motor_two, motor_three, motor_four, idle_bypass,
                  output ready);
endinterface

interface qmm_cfg_if;
  import qmm_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/quad_motor_mixer_averaged_unit.sv
// ----------------------------------------------------------------------------
// quad_motor_mixer_averaged_unit
// moving-average receiver filter and x-frame motor mixer
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_ch    in   throttle, roll, pitch, yaw samples
//  out_ch   out  four motor commands, idle bypass flag
//  cfg_ch   in   register index, write data (always ready)
//
//  one beat per cycle while out_ch is ready, via sum, average, product and motor registers
//  stages: window sum, divide by reciprocal multiply, gain multiply, mix and clamp
//  every stage holds its beat while the next is full, bubbles are squeezed out
//  synchronous active-low reset: windows and sums preloaded, config and valids reset
// ----------------------------------------------------------------------------
module quad_motor_mixer_averaged_unit
  import qmm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  qmm_cfg_if.sink   cfg_ch,
  qmm_in_if.sink    in_ch,
  qmm_out_if.source out_ch
);

  cfg_t    cfg_r;
  sample_t win_r [CH_COUNT][WINDOW_LENGTH];
  sum_t    sum_r [CH_COUNT];
  sum_t    sum_nxt [CH_COUNT];
  sample_t smp [CH_COUNT];
  sample_t avg_r [CH_COUNT];
  sample_t avg_nxt [CH_COUNT];
  prod_t   prd_r [3];
  prod_t   prd_nxt [3];
  sample_t thr_r;
  logic    idle_r;
  motor_t  mot_r [CH_COUNT];
  motor_t  mot_nxt [CH_COUNT];
  logic    byp_r;

  logic v1_r, v2_r, v3_r, ov_r;
  logic rdy2, rdy3, rdy4;
  logic acc, ld2, ld3, ld4;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roll_gain      <= GAIN_RESET;
      cfg_r.pitch_gain     <= GAIN_RESET;
      cfg_r.yaw_gain       <= GAIN_RESET;
      cfg_r.idle_threshold <= IDLE_RESET;
      cfg_r.pwm_floor      <= FLOOR_RESET;
      cfg_r.pwm_ceiling    <= CEILING_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROLL_GAIN:      cfg_r.roll_gain      <= gain_t'(cfg_ch.data);
        REG_PITCH_GAIN:     cfg_r.pitch_gain     <= gain_t'(cfg_ch.data);
        REG_YAW_GAIN:       cfg_r.yaw_gain       <= gain_t'(cfg_ch.data);
        REG_IDLE_THRESHOLD: cfg_r.idle_threshold <= cfg_ch.data[OUT_BITS-1:0];
        REG_PWM_FLOOR:      cfg_r.pwm_floor      <= cfg_ch.data[OUT_BITS-1:0];
        REG_PWM_CEILING:    cfg_r.pwm_ceiling    <= cfg_ch.data[OUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  assign rdy4        = !ov_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign in_ch.ready = !v1_r || rdy2;
  assign acc         = in_ch.valid && in_ch.ready;
  assign ld2         = v1_r && rdy2;
  assign ld3         = v2_r && rdy3;
  assign ld4         = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (acc)              v1_r <= 1'b1;
      else if (ld2)         v1_r <= 1'b0;
      if (ld2)              v2_r <= 1'b1;
      else if (ld3)         v2_r <= 1'b0;
      if (ld3)              v3_r <= 1'b1;
      else if (ld4)         v3_r <= 1'b0;
      if (ld4)              ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // stage 1: windows and running sums
  assign smp[CH_THR]   = sample_t'(in_ch.throttle_sample);
  assign smp[CH_ROLL]  = sample_t'(in_ch.roll_sample);
  assign smp[CH_PITCH] = sample_t'(in_ch.pitch_sample);
  assign smp[CH_YAW]   = sample_t'(in_ch.yaw_sample);

  always_comb begin
    for (int c = 0; c < CH_COUNT; c++) begin
      sum_nxt[c] = sum_r[c] + sum_t'(smp[c]) - sum_t'(win_r[c][WINDOW_LENGTH-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        for (int i = 1; i < WINDOW_LENGTH; i++) begin
          win_r[c][i] <= '0;
        end
        win_r[c][0] <= WIN_HEAD_RESET;
        sum_r[c]    <= sum_t'(WIN_HEAD_RESET);
      end
    end else if (acc) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        win_r[c][0] <= smp[c];
        for (int i = 1; i < WINDOW_LENGTH; i++) begin
          win_r[c][i] <= win_r[c][i-1];
        end
        sum_r[c] <= sum_nxt[c];
      end
    end
  end

  // stage 2: floor divide by the window length
  always_comb begin
    div_prod_t q;
    for (int c = 0; c < CH_COUNT; c++) begin
      q          = div_prod_t'(sum_r[c]) * div_prod_t'(RECIP);
      avg_nxt[c] = q[DIV_SHIFT +: SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int c = 0; c < CH_COUNT; c++) avg_r[c] <= avg_nxt[c];
    end
  end

  // stage 3: centre and scale
  function automatic prod_t scale(input sample_t avg, input gain_t gain);
    cent_t cent;
    cent  = cent_t'({1'b0, avg}) - cent_t'(CENTER);
    return prod_t'(gain) * prod_t'(cent);
  endfunction

  assign prd_nxt[0] = scale(avg_r[CH_ROLL],  cfg_r.roll_gain);
  assign prd_nxt[1] = scale(avg_r[CH_PITCH], cfg_r.pitch_gain);
  assign prd_nxt[2] = scale(avg_r[CH_YAW],   cfg_r.yaw_gain);

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int k = 0; k < 3; k++) prd_r[k] <= prd_nxt[k];
      thr_r  <= avg_r[CH_THR];
      idle_r <= WIDE_BITS'(avg_r[CH_THR]) < WIDE_BITS'(cfg_r.idle_threshold);
    end
  end

  // stage 4: mix and clamp
  function automatic motor_t clamp(input mix_t q, input motor_t flo, input motor_t ceil_v);
    mix_t m;
    m = q >>> FRAC_BITS;
    if (q < mix_t'(LOW_CUT_Q)) return flo;
    if (m > mix_t'(ceil_v))   return ceil_v;
    return m[OUT_BITS-1:0];
  endfunction

  always_comb begin
    mix_t   base, r, p, y;
    motor_t thr_out;
    base = mix_t'({thr_r, FRAC_BITS'(0)});
    r    = mix_t'(prd_r[0]);
    p    = mix_t'(prd_r[1]);
    y    = mix_t'(prd_r[2]);
    if (WIDE_BITS'(thr_r) > WIDE_BITS'(OUT_MAX)) thr_out = motor_t'(OUT_MAX);
    else                                          thr_out = thr_r[OUT_BITS-1:0];
    if (idle_r) begin
      for (int c = 0; c < CH_COUNT; c++) mot_nxt[c] = thr_out;
    end else begin
      mot_nxt[0] = clamp(base + r - p + y, cfg_r.pwm_floor, cfg_r.pwm_ceiling);
      mot_nxt[1] = clamp(base - r - p - y, cfg_r.pwm_floor, cfg_r.pwm_ceiling);
      mot_nxt[2] = clamp(base - r + p + y, cfg_r.pwm_floor, cfg_r.pwm_ceiling);
      mot_nxt[3] = clamp(base + r + p - y, cfg_r.pwm_floor, cfg_r.pwm_ceiling);
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      for (int c = 0; c < CH_COUNT; c++) mot_r[c] <= mot_nxt[c];
      byp_r <= idle_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.motor_one   = mot_r[0];
  assign out_ch.motor_two   = mot_r[1];
  assign out_ch.motor_three = mot_r[2];
  assign out_ch.motor_four  = mot_r[3];
  assign out_ch.idle_bypass = byp_r;

  // checks
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> v1_r) else $error("accepted beat not held in first stage");

  a_result_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !ov_r |=> ov_r) else $error("result stage did not load");

  a_idle_equal: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && byp_r |-> (mot_r[0] == mot_r[1]) && (mot_r[1] == mot_r[2]) &&
                      (mot_r[2] == mot_r[3])) else $error("idle motors differ");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result valid after reset");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the averaged quad motor mixer against an in-bench mixer predictor.
// A short table of directed beats comes first: reset windows, full-scale
// sticks, centred sticks and the edge of the idle threshold. Random stick
// runs with jitter and some noise follow under several register settings.
// Both channels idle at random. Each result beat is compared field by
// field with the oldest predicted command.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qmm_pkg::*;

  localparam int DIRECTED_COUNT   = 22;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int PHASE_COUNT      = 6;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int FIELD_MAX        = (1 << IN_BITS) - 1;

  localparam cfg_idx_t REG_SPARE_SIX   = 3'd6;
  localparam cfg_idx_t REG_SPARE_SEVEN = 3'd7;

  typedef struct packed {
    motor_t motor_one;
    motor_t motor_two;
    motor_t motor_three;
    motor_t motor_four;
    logic   idle_bypass;
  } motor_beat_t;

  typedef struct packed {
    field_t      throttle;
    field_t      roll;
    field_t      pitch;
    field_t      yaw;
    logic        typed;
    motor_beat_t want;
  } steer_row_t;

  logic clk;
  logic rst_n;

  qmm_in_if  in_if();
  qmm_out_if out_if();
  qmm_cfg_if cfg_if();

  quad_motor_mixer_averaged_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  sample_t     windows [CH_COUNT][WINDOW_LENGTH];
  cfg_t        shadow;
  motor_beat_t motor_queue [$];
  steer_row_t  directed_rows [DIRECTED_COUNT];
  int          fail_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d commands outstanding",
             cycle_count, motor_queue.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic field_t clip_sample(input int v);
    if (v < 0) return '0;
    if (v > FIELD_MAX) return field_t'(FIELD_MAX);
    return field_t'(v);
  endfunction

  function automatic motor_t clamp_command(input longint q);
    longint m;
    if (q < longint'(LOW_CUT_Q)) return shadow.pwm_floor;
    m = q >>> FRAC_BITS;
    if (m > longint'(shadow.pwm_ceiling)) m = longint'(shadow.pwm_ceiling);
    return motor_t'(m);
  endfunction

  function automatic motor_beat_t mix_predict(input field_t t, input field_t r,
                                              input field_t p, input field_t y);
    field_t      raw [CH_COUNT];
    int          avg [CH_COUNT];
    int          sum;
    longint      base;
    longint      rq;
    longint      pq;
    longint      yq;
    motor_beat_t beat;
    raw[CH_THR]   = t;
    raw[CH_ROLL]  = r;
    raw[CH_PITCH] = p;
    raw[CH_YAW]   = y;
    for (int c = 0; c < CH_COUNT; c++) begin
      for (int i = WINDOW_LENGTH - 1; i > 0; i--) windows[c][i] = windows[c][i-1];
      windows[c][0] = sample_t'(raw[c]);
      sum = 0;
      for (int i = 0; i < WINDOW_LENGTH; i++) sum += int'(windows[c][i]);
      avg[c] = sum / WINDOW_LENGTH;
    end
    if (avg[CH_THR] < int'(shadow.idle_threshold)) begin
      beat.motor_one   = motor_t'(avg[CH_THR]);
      beat.motor_two   = motor_t'(avg[CH_THR]);
      beat.motor_three = motor_t'(avg[CH_THR]);
      beat.motor_four  = motor_t'(avg[CH_THR]);
      beat.idle_bypass = 1'b1;
      return beat;
    end
    base = longint'(avg[CH_THR]) <<< FRAC_BITS;
    rq = longint'(shadow.roll_gain)  * longint'(avg[CH_ROLL]  - CENTER);
    pq = longint'(shadow.pitch_gain) * longint'(avg[CH_PITCH] - CENTER);
    yq = longint'(shadow.yaw_gain)   * longint'(avg[CH_YAW]   - CENTER);
    beat.motor_one   = clamp_command(base + rq - pq + yq);
    beat.motor_two   = clamp_command(base - rq - pq - yq);
    beat.motor_three = clamp_command(base - rq + pq + yq);
    beat.motor_four  = clamp_command(base + rq + pq - yq);
    beat.idle_bypass = 1'b0;
    return beat;
  endfunction

  // entered and left at a falling edge
  task automatic send_sample(input field_t t, input field_t r, input field_t p,
                             input field_t y, input logic typed,
                             input motor_beat_t typed_beat);
    motor_beat_t beat;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.throttle_sample <= t;
    in_if.roll_sample     <= r;
    in_if.pitch_sample    <= p;
    in_if.yaw_sample      <= y;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beat = mix_predict(t, r, p, y);
    motor_queue.push_back(typed ? typed_beat : beat);
    @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_ROLL_GAIN:      shadow.roll_gain      = gain_t'(data);
      REG_PITCH_GAIN:     shadow.pitch_gain     = gain_t'(data);
      REG_YAW_GAIN:       shadow.yaw_gain       = gain_t'(data);
      REG_IDLE_THRESHOLD: shadow.idle_threshold = motor_t'(data);
      REG_PWM_FLOOR:      shadow.pwm_floor      = motor_t'(data);
      REG_PWM_CEILING:    shadow.pwm_ceiling    = motor_t'(data);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input int which);
    int rg;
    int pg;
    int yg;
    int idle;
    int flo;
    int cei;
    case (which)
      1: begin
        rg = 32767; pg = -32768; yg = 0;
        idle = 0; flo = 4095; cei = 4095;
      end
      2: begin
        // ceiling under the low cut
        rg = -32768; pg = 32767; yg = 4096;
        idle = 4095; flo = 0; cei = 0;
      end
      3: begin
        rg = int'($urandom_range(16384)) - 8192;
        pg = int'($urandom_range(16384)) - 8192;
        yg = int'($urandom_range(16384)) - 8192;
        idle = $urandom_range(800, 1600);
        flo = $urandom_range(4095);
        cei = $urandom_range(LOW_CUT, 4095);
      end
      4: begin
        rg = int'(gain_t'($urandom));
        pg = int'(gain_t'($urandom));
        yg = int'(gain_t'($urandom));
        idle = $urandom_range(4095);
        flo = $urandom_range(4095);
        cei = $urandom_range(4095);
      end
      default: begin
        rg = int'(GAIN_RESET); pg = int'(GAIN_RESET); yg = int'(GAIN_RESET);
        idle = int'(IDLE_RESET); flo = int'(FLOOR_RESET); cei = int'(CEILING_RESET);
      end
    endcase
    cfg_write(REG_SPARE_SIX, cfg_data_t'($urandom));
    cfg_write(REG_ROLL_GAIN, cfg_data_t'(rg));
    cfg_write(REG_PITCH_GAIN, cfg_data_t'(pg));
    cfg_write(REG_YAW_GAIN, cfg_data_t'(yg));
    cfg_write(REG_IDLE_THRESHOLD, {4'($urandom), 12'(idle)});
    cfg_write(REG_PWM_FLOOR, {4'($urandom), 12'(flo)});
    cfg_write(REG_PWM_CEILING, {4'($urandom), 12'(cei)});
    cfg_write(REG_SPARE_SEVEN, cfg_data_t'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_if.ready <= (rx_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    motor_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (motor_queue.size() == 0) begin
        report_mismatch("beat with no command waiting", 0, 0);
      end else begin
        want = motor_queue.pop_front();
        if (out_if.motor_one !== want.motor_one)
          report_mismatch("motor_one", out_if.motor_one, want.motor_one);
        if (out_if.motor_two !== want.motor_two)
          report_mismatch("motor_two", out_if.motor_two, want.motor_two);
        if (out_if.motor_three !== want.motor_three)
          report_mismatch("motor_three", out_if.motor_three, want.motor_three);
        if (out_if.motor_four !== want.motor_four)
          report_mismatch("motor_four", out_if.motor_four, want.motor_four);
        if (out_if.idle_bypass !== want.idle_bypass)
          report_mismatch("idle_bypass", out_if.idle_bypass, want.idle_bypass);
      end
    end
  end

  initial begin : stimulus
    int     run_left;
    int     level [CH_COUNT];
    field_t pick [CH_COUNT];
    steer_row_t row;
    fail_count  = 0;
    tx_idle_pct = 16;
    rx_idle_pct = 64;
    run_left    = 0;
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.throttle_sample = '0;
    in_if.roll_sample     = '0;
    in_if.pitch_sample    = '0;
    in_if.yaw_sample      = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    for (int c = 0; c < CH_COUNT; c++) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) windows[c][i] = '0;
      windows[c][0] = WIN_HEAD_RESET;
    end
    shadow = '{GAIN_RESET, GAIN_RESET, GAIN_RESET, IDLE_RESET, FLOOR_RESET, CEILING_RESET};

    directed_rows = '{
      // reset windows, idle bypass
      '{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, '{12'd200, 12'd200, 12'd200, 12'd200, 1'b1}},
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
      // full scale, ceiling and low cut
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, '{12'd2000, 12'd1000, 12'd2000, 12'd2000, 1'b0}},
      '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      // centred sticks
      '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b1, '{12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0}},
      '{12'd1100, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      '{12'd1100, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      '{12'd1100, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      '{12'd1100, 12'd1500, 12'd1500, 12'd1500, 1'b0, '0},
      // throttle right on the idle threshold
      '{12'd1100, 12'd1500, 12'd1500, 12'd1500, 1'b1, '{12'd1100, 12'd1100, 12'd1100, 12'd1100, 1'b0}},
      // one under it
      '{12'd1099, 12'd1500, 12'd1500, 12'd1500, 1'b1, '{12'd1099, 12'd1099, 12'd1099, 12'd1099, 1'b1}},
      '{12'd4095, 12'd4095, 12'd0,    12'd1500, 1'b0, '0},
      '{12'd4095, 12'd0,    12'd4095, 12'd0,    1'b0, '0},
      '{12'd2048, 12'd1500, 12'd1500, 12'd4095, 1'b0, '0},
      '{12'hAAA,  12'h555,  12'hAAA,  12'h555,  1'b0, '0},
      '{12'h555,  12'hAAA,  12'h555,  12'hAAA,  1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      row = directed_rows[k];
      send_sample(row.throttle, row.roll, row.pitch, row.yaw, row.typed, row.want);
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == 2) begin
        tx_idle_pct = 64;
        rx_idle_pct = 16;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase != 0) begin
        in_if.valid <= 1'b0;
        do @(negedge clk); while (motor_queue.size() != 0);
        apply_setting(phase);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 1 && n == RANDOM_PER_PHASE / 2) begin
          // hold off until the pipe has emptied
          in_if.valid <= 1'b0;
          do @(negedge clk); while (motor_queue.size() != 0);
        end
        if (run_left == 0) begin
          run_left = $urandom_range(5, 14);
          for (int c = 0; c < CH_COUNT; c++) begin
            case ($urandom_range(3))
              0: level[c] = $urandom_range(FIELD_MAX);
              1: level[c] = CENTER - 200 + int'($urandom_range(400));
              2: level[c] = int'(shadow.idle_threshold) - 20 + int'($urandom_range(40));
              default: level[c] = $urandom_range(1) ? FIELD_MAX : 0;
            endcase
          end
        end
        run_left--;
        if ($urandom_range(7) == 0) begin
          for (int c = 0; c < CH_COUNT; c++) pick[c] = field_t'($urandom);
        end else begin
          for (int c = 0; c < CH_COUNT; c++)
            pick[c] = clip_sample(level[c] + int'($urandom_range(16)) - 8);
        end
        send_sample(pick[CH_THR], pick[CH_ROLL], pick[CH_PITCH], pick[CH_YAW], 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (motor_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
